// File: design/lzwc_pkg.sv
// Shared types and constants for the LZW byte compressor.
// Used by every module of the block; depends on nothing else.
package lzwc_pkg;

    localparam int HASH_SLOTS_DEF = 131072;
    localparam int CODE_W         = 16;
    localparam int KEY_W          = 24;
    localparam int EPOCH_W        = 4;
    localparam int HASH_LAT       = 5;

    localparam logic [CODE_W-1:0]  FIRST_CODE = 16'd256;
    localparam logic [CODE_W-1:0]  AFTER_FIRST_CODE = 16'd257;
    localparam logic [EPOCH_W-1:0] EPOCH_MAX  = '1;

    // One dictionary slot: live only while it is valid and its tag matches the current epoch.
    typedef struct packed {
        logic               valid;
        logic [EPOCH_W-1:0] epoch;
        logic [KEY_W-1:0]   key;
        logic [CODE_W-1:0]  code;
    } dict_word_t;

    typedef enum logic [2:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_HASH,
        ST_READ,
        ST_CHECK,
        ST_EMIT_MISS,
        ST_LEARN,
        ST_EMIT_LAST
    } state_t;

endpackage

// File: design/lzwc_hash.sv
// Pipelined slot hash for the LZW dictionary: multiplicative hash, then
// reduction modulo the slot count by reciprocal multiply and correction.
// Depends on lzwc_pkg.
module lzwc_hash
    import lzwc_pkg::*;
#(
    parameter int HASH_SLOTS = HASH_SLOTS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [KEY_W-1:0]              key,
    output logic                          done,
    output logic [$clog2(HASH_SLOTS)-1:0] idx
);

    localparam int IDX_W = $clog2(HASH_SLOTS);
    localparam int R_W   = IDX_W + 2;
    localparam logic [63:0] RM_FULL = 64'h1_0000_0000 / HASH_SLOTS;
    localparam logic [16:0] RM      = RM_FULL[16:0];
    localparam logic [63:0] N_FULL  = 64'(HASH_SLOTS);
    localparam logic [IDX_W:0] NV   = N_FULL[IDX_W:0];
    localparam logic [R_W-1:0] N1   = N_FULL[R_W-1:0];
    localparam logic [R_W-1:0] N2   = R_W'(N_FULL << 1);

    logic [HASH_LAT-1:0] vld_reg;
    logic [31:0]         h1_reg;
    logic [31:0]         h2_reg;
    logic [15:0]         q2_reg;
    logic [R_W-1:0]      r3_reg;
    logic [R_W-1:0]      r4_reg;
    logic [IDX_W-1:0]    idx_reg;

    logic [KEY_W-1:0]    mixed;
    logic [31:0]         h2_next;
    logic [32:0]         q_prod;
    logic [31:0]         r_diff;

    always_comb
    begin
        mixed   = key ^ (key >> 11);
        h2_next = h1_reg ^ (h1_reg >> 15);
        q_prod  = 33'(h2_next[31:16]) * 33'(RM);
        r_diff  = h2_reg - 32'(q2_reg * NV);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[HASH_LAT-2:0], start};
        end
    end

    // The estimated quotient is at most three below the true one, so two
    // conditional subtractions bring the remainder into range.
    always_ff @(posedge clk)
    begin
        h1_reg  <= 32'(mixed) * 32'h9E3779B1;
        h2_reg  <= h2_next;
        q2_reg  <= q_prod[31:16];
        r3_reg  <= r_diff[R_W-1:0];
        r4_reg  <= (r3_reg >= N2) ? (r3_reg - N2) : r3_reg;
        idx_reg <= (r4_reg >= N1) ? IDX_W'(r4_reg - N1) : r4_reg[IDX_W-1:0];
    end

    assign done = vld_reg[HASH_LAT-1];
    assign idx  = idx_reg;

endmodule

// File: design/lzwc_dict_ram.sv
// Dictionary memory: one write port, one read port with registered data.
// Depends on lzwc_pkg for the slot layout.
module lzwc_dict_ram
    import lzwc_pkg::*;
#(
    parameter int HASH_SLOTS = HASH_SLOTS_DEF
)
(
    input  logic                          clk,
    input  logic                          wr_en,
    input  logic [$clog2(HASH_SLOTS)-1:0] wr_addr,
    input  dict_word_t                    wr_data,
    input  logic                          rd_en,
    input  logic [$clog2(HASH_SLOTS)-1:0] rd_addr,
    output dict_word_t                    rd_data
);

    dict_word_t mem [HASH_SLOTS];
    dict_word_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: design/lzwc_out_queue.sv
// Two-entry result queue between the compressor control and the output
// channel. Depends on lzwc_pkg.
module lzwc_out_queue
    import lzwc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [CODE_W-1:0] push_code,
    input  logic              push_last,
    output logic              full,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [CODE_W-1:0] code,
    output logic              last_code
);

    logic [CODE_W-1:0] code_mem [2];
    logic              last_mem [2];
    logic              wr_ptr_reg;
    logic              wr_ptr_next;
    logic              rd_ptr_reg;
    logic              rd_ptr_next;
    logic [1:0]        count_reg;
    logic [1:0]        count_next;
    logic              pop;

    always_comb
    begin
        pop         = (count_reg != 2'd0) && !out_stall;
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            code_mem[wr_ptr_reg] <= push_code;
            last_mem[wr_ptr_reg] <= push_last;
        end
    end

    assign full      = (count_reg == 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign code      = code_mem[rd_ptr_reg];
    assign last_code = last_mem[rd_ptr_reg];

endmodule

// File: design/lzw_byte_compressor_core.sv
// LZW byte compressor with fixed 16-bit codes. After reset the block clears its
// whole dictionary memory before the first byte is taken. A byte that starts
// a message goes straight into the prefix; any other byte passes through the
// hash pipeline and then one dictionary probe per slot tried (one memory read
// and one compare), then waits for each code it emits to enter the result
// queue and learns a new entry on a miss. Dictionary clears are done by
// advancing an epoch tag; a clear at the largest tag value instead runs a
// full clearing pass over the memory. Results wait in a two-entry queue.
module lzw_byte_compressor_core
    import lzwc_pkg::*;
#(
    parameter int HASH_SLOTS = HASH_SLOTS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [7:0]        data_byte,
    input  logic              end_of_message,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [CODE_W-1:0] code,
    output logic              last_code
);

    localparam int IDX_W = $clog2(HASH_SLOTS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(HASH_SLOTS - 1);

    state_t             state_reg, state_next;
    state_t             ret_reg, ret_next;
    logic [CODE_W-1:0]  prefix_reg, prefix_next;
    logic               have_reg, have_next;
    logic [CODE_W-1:0]  ncode_reg, ncode_next;
    logic [EPOCH_W-1:0] epoch_reg, epoch_next;
    logic [7:0]         byte_reg, byte_next;
    logic               eom_reg, eom_next;
    logic [KEY_W-1:0]   key_reg, key_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [IDX_W-1:0]   hidx_reg, hidx_next;
    logic [IDX_W-1:0]   sweep_reg, sweep_next;

    logic               hash_start;
    logic               hash_done;
    logic [IDX_W-1:0]   hash_idx;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    dict_word_t         wr_data;
    logic               rd_en;
    dict_word_t         rd_data;
    logic               q_push;
    logic [CODE_W-1:0]  q_code;
    logic               q_last;
    logic               q_full;

    logic               slot_live;
    logic               slot_hit;
    logic               code_wrap;
    logic               eom_clear;

    always_comb
    begin
        slot_live = rd_data.valid && (rd_data.epoch == epoch_reg);
        slot_hit  = slot_live && (rd_data.key == key_reg);
        code_wrap = (ncode_reg == '0);
        eom_clear = (ncode_reg != FIRST_CODE);
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_SWEEP:
            begin
                if (sweep_reg == LAST_IDX)
                begin
                    state_next = ret_reg;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (have_reg)
                    begin
                        state_next = ST_HASH;
                    end
                    else if (end_of_message)
                    begin
                        state_next = ST_EMIT_LAST;
                    end
                end
            end
            ST_HASH:
            begin
                if (hash_done)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (slot_hit)
                begin
                    state_next = eom_reg ? ST_EMIT_LAST : ST_IDLE;
                end
                else if (!slot_live)
                begin
                    state_next = ST_EMIT_MISS;
                end
                else
                begin
                    state_next = ST_READ;
                end
            end
            ST_EMIT_MISS:
            begin
                if (!q_full)
                begin
                    state_next = ST_LEARN;
                end
            end
            ST_LEARN:
            begin
                if (code_wrap && (epoch_reg == EPOCH_MAX))
                begin
                    state_next = ST_SWEEP;
                end
                else
                begin
                    state_next = eom_reg ? ST_EMIT_LAST : ST_IDLE;
                end
            end
            ST_EMIT_LAST:
            begin
                if (!q_full)
                begin
                    if (eom_clear && (epoch_reg == EPOCH_MAX))
                    begin
                        state_next = ST_SWEEP;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Input stall and outputs toward the hash unit, the memory and the result queue.
    always_comb
    begin
        in_stall   = 1'b1;
        hash_start = 1'b0;
        rd_en      = 1'b0;
        wr_en      = 1'b0;
        wr_addr    = idx_reg;
        wr_data    = '0;
        q_push     = 1'b0;
        q_code     = prefix_reg;
        q_last     = 1'b0;
        case (state_reg)
            ST_SWEEP:
            begin
                wr_en   = 1'b1;
                wr_addr = sweep_reg;
            end
            ST_IDLE:
            begin
                in_stall   = 1'b0;
                hash_start = in_valid && have_reg;
            end
            ST_READ:
            begin
                rd_en = 1'b1;
            end
            ST_EMIT_MISS:
            begin
                q_push = !q_full;
            end
            ST_LEARN:
            begin
                // After a clear the table is empty, so the home slot is free.
                if (code_wrap)
                begin
                    wr_en         = (epoch_reg != EPOCH_MAX);
                    wr_addr       = hidx_reg;
                    wr_data.valid = 1'b1;
                    wr_data.epoch = epoch_reg + 1'b1;
                    wr_data.key   = key_reg;
                    wr_data.code  = FIRST_CODE;
                end
                else
                begin
                    wr_en         = 1'b1;
                    wr_data.valid = 1'b1;
                    wr_data.epoch = epoch_reg;
                    wr_data.key   = key_reg;
                    wr_data.code  = ncode_reg;
                end
            end
            ST_EMIT_LAST:
            begin
                q_push = !q_full;
                q_last = 1'b1;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    // Datapath registers.
    always_comb
    begin
        ret_next    = ret_reg;
        prefix_next = prefix_reg;
        have_next   = have_reg;
        ncode_next  = ncode_reg;
        epoch_next  = epoch_reg;
        byte_next   = byte_reg;
        eom_next    = eom_reg;
        key_next    = key_reg;
        idx_next    = idx_reg;
        hidx_next   = hidx_reg;
        sweep_next  = sweep_reg;
        case (state_reg)
            ST_SWEEP:
            begin
                sweep_next = (sweep_reg == LAST_IDX) ? '0 : sweep_reg + 1'b1;
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    byte_next = data_byte;
                    eom_next  = end_of_message;
                    key_next  = {prefix_reg, data_byte};
                    if (!have_reg)
                    begin
                        prefix_next = CODE_W'(data_byte);
                        have_next   = 1'b1;
                    end
                end
            end
            ST_HASH:
            begin
                if (hash_done)
                begin
                    idx_next  = hash_idx;
                    hidx_next = hash_idx;
                end
            end
            ST_CHECK:
            begin
                if (slot_hit)
                begin
                    prefix_next = rd_data.code;
                end
                else if (slot_live)
                begin
                    idx_next = (idx_reg == LAST_IDX) ? '0 : idx_reg + 1'b1;
                end
            end
            ST_LEARN:
            begin
                if (code_wrap && (epoch_reg == EPOCH_MAX))
                begin
                    // Sweep the memory, then come back here with a fresh epoch.
                    epoch_next = '0;
                    ret_next   = ST_LEARN;
                end
                else if (code_wrap)
                begin
                    epoch_next  = epoch_reg + 1'b1;
                    ncode_next  = AFTER_FIRST_CODE;
                    prefix_next = CODE_W'(byte_reg);
                end
                else
                begin
                    ncode_next  = ncode_reg + 1'b1;
                    prefix_next = CODE_W'(byte_reg);
                end
            end
            ST_EMIT_LAST:
            begin
                if (!q_full)
                begin
                    have_next   = 1'b0;
                    prefix_next = '0;
                    ncode_next  = FIRST_CODE;
                    ret_next    = ST_IDLE;
                    if (eom_clear)
                    begin
                        epoch_next = (epoch_reg == EPOCH_MAX) ? '0 : epoch_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                ret_next = ret_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_SWEEP;
            ret_reg    <= ST_IDLE;
            prefix_reg <= '0;
            have_reg   <= 1'b0;
            ncode_reg  <= FIRST_CODE;
            epoch_reg  <= '0;
            sweep_reg  <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            ret_reg    <= ret_next;
            prefix_reg <= prefix_next;
            have_reg   <= have_next;
            ncode_reg  <= ncode_next;
            epoch_reg  <= epoch_next;
            sweep_reg  <= sweep_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        eom_reg  <= eom_next;
        key_reg  <= key_next;
        idx_reg  <= idx_next;
        hidx_reg <= hidx_next;
    end

    lzwc_hash #(
        .HASH_SLOTS (HASH_SLOTS)
    ) u_hash (
        .clk   (clk),
        .rst_n (rst_n),
        .start (hash_start),
        .key   ({prefix_reg, data_byte}),
        .done  (hash_done),
        .idx   (hash_idx)
    );

    lzwc_dict_ram #(
        .HASH_SLOTS (HASH_SLOTS)
    ) u_dict (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (idx_reg),
        .rd_data (rd_data)
    );

    lzwc_out_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_code (q_code),
        .push_last (q_last),
        .full      (q_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .code      (code),
        .last_code (last_code)
    );

endmodule

// File: design/lzwc_checker.sv
// Port-level checks for the LZW byte compressor, bound to the top level.
// Depends on lzwc_pkg and lzw_byte_compressor_core.
module lzwc_checker
    import lzwc_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_stall,
    input logic              end_of_message,
    input logic              out_valid,
    input logic              out_stall,
    input logic [CODE_W-1:0] code,
    input logic              last_code
);

    // A stalled result holds its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(code) && $stable(last_code))
    else $error("stalled result changed");

    // A result only goes away through a transfer.
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(out_valid) |-> $past(!out_stall))
    else $error("result dropped without transfer");

    // The final byte of a message always leaves a code to flush.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && end_of_message |=> in_stall)
    else $error("end of message accepted without flush");

    // Input is stalled when reset is released, while the dictionary clear runs.
    assert property (@(posedge clk)
        rst_n && !$past(rst_n) |-> in_stall)
    else $error("byte taken before dictionary clear");

endmodule

bind lzw_byte_compressor_core lzwc_checker u_lzwc_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .end_of_message (end_of_message),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .code           (code),
    .last_code      (last_code)
);
